@@ sv/bfd_pkg.sv @@
// Shared types and constants of the frequency band decoder.
package bfd_pkg;

  // Request kinds.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_RULE = 1'b1;

  // Frame delimiters and the two accepted command codes in byte 4.
  localparam logic [7:0] MARK_START = 8'hFE;
  localparam logic [7:0] MARK_END   = 8'hFD;
  localparam logic [7:0] CMD_FREQ   = 8'h00;
  localparam logic [7:0] CMD_READ   = 8'h03;

  // Frame layout.
  localparam int MIN_FRAME    = 10;
  localparam int CMD_POS      = 4;
  localparam int FREQ_MSB_POS = 9;
  localparam int DIGIT_PAIRS  = 5;

  // Hz to kHz: floor(x / 1000) == (x * KHZ_RECIP) >> KHZ_SHIFT for any 32-bit x.
  localparam logic [31:0] KHZ_RECIP = 32'h10624DD3;
  localparam int          KHZ_SHIFT = 38;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_CHK,
    S_DIGIT,
    S_SCALE,
    S_QUOT,
    S_RULE_RD,
    S_SEARCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] low_khz;
    logic [31:0] end_khz;
    logic [7:0]  band;
    logic [7:0]  mode;
  } rule_entry_t;

endpackage

@@ sv/bfd_ifaces.sv @@
// Request and result channel interfaces of the frequency band decoder.
interface bfd_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  serial_byte;
  logic [3:0]  rule_index;
  logic [31:0] rule_start_khz;
  logic [31:0] rule_end_khz;
  logic [7:0]  rule_band;
  logic [7:0]  rule_mode;

  modport source (
    output valid, op, serial_byte, rule_index, rule_start_khz, rule_end_khz,
           rule_band, rule_mode,
    input  ready
  );
  modport sink (
    input  valid, op, serial_byte, rule_index, rule_start_khz, rule_end_khz,
           rule_band, rule_mode,
    output ready
  );
endinterface

interface bfd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] band;
  logic [7:0] mode;

  modport source (output valid, band, mode, input ready);
  modport sink (input valid, band, mode, output ready);
endinterface

@@ sv/bfd_rule_mem.sv @@
// Rule table memory: one write port and one registered read port.
module bfd_rule_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  bfd_pkg::rule_entry_t wdata,
  input  logic [AW-1:0]        raddr,
  output bfd_pkg::rule_entry_t rdata
);
  import bfd_pkg::*;

  rule_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bcd_frequency_band_decoder_unit.sv @@
// Top level of the frequency band decoder: frame capture, BCD decode and rule search.
// Serial bytes and rule writes that do not end a frame are taken and leave the block idle.
// A frame end that passes the length check keeps the block busy up to the byte 4 check if
// that byte is wrong, otherwise through the digit, scale and quotient steps, the rule read
// and search when rules are enabled, and the emit step, which waits for the output to free.
// Synchronous active-high reset clears the byte position, rule_count and the result flag.
module bcd_frequency_band_decoder_unit #(
  parameter int MAX_RULE_ENTRIES = 16,
  parameter int FRAME_BYTES      = 32
) (
  input  logic           clk,
  input  logic           rst,
  bfd_req_if.sink        req,
  bfd_rsp_if.source      rsp,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data
);
  import bfd_pkg::*;

  // Address and counter widths. Counters that must hold the depth itself get one more bit.
  localparam int FIDX_W = $clog2(FRAME_BYTES);
  localparam int POS_W  = $clog2(FRAME_BYTES + 1);
  localparam int RIDX_W = (MAX_RULE_ENTRIES > 1) ? $clog2(MAX_RULE_ENTRIES) : 1;
  localparam int RCNT_W = $clog2(MAX_RULE_ENTRIES + 1);

  // Control state.
  state_t            state, state_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [4:0]        rule_count;
  logic              out_valid, out_valid_next;

  // Datapath registers.
  logic [FIDX_W-1:0] rd_addr, rd_addr_next;
  logic [2:0]        dig_cnt, dig_cnt_next;
  logic [31:0]       acc, acc_next;
  logic [63:0]       prod, prod_next;
  logic [RCNT_W-1:0] n_reg, n_reg_next;
  logic [RCNT_W-1:0] srch_idx, srch_idx_next;
  logic [RIDX_W-1:0] r_addr, r_addr_next;
  logic [7:0]        hit_band, hit_band_next;
  logic [7:0]        hit_mode, hit_mode_next;
  logic [7:0]        out_band, out_band_next;
  logic [7:0]        out_mode, out_mode_next;

  // The frame store holds the bytes of the frame being received.
  logic [7:0]        fmem [FRAME_BYTES];
  logic [7:0]        f_rdata;
  logic              f_we;

  // Rule table port signals.
  logic              r_we;
  rule_entry_t       r_wdata;
  rule_entry_t       r_rdata;

  logic              accept;
  logic [7:0]        digit;
  logic [31:0]       acc_mul;
  logic [31:0]       khz;
  logic              rule_hit;
  logic [RCNT_W-1:0] n_eff;

  // A request is taken only while the sequencer is idle. The result register lets a new
  // request in while an earlier result still waits at the output.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid = out_valid;
  assign rsp.band  = out_band;
  assign rsp.mode  = out_mode;

  // One BCD digit pair, each nibble taken at face value.
  assign digit   = ({4'b0, f_rdata[7:4]} * 8'd10) + {4'b0, f_rdata[3:0]};
  assign acc_mul = acc * 32'd100;

  // The quotient by 1000 is a fixed shift of the registered reciprocal product.
  assign khz = 32'(prod >> KHZ_SHIFT);

  assign rule_hit = (khz >= r_rdata.low_khz) && (khz < r_rdata.end_khz);

  // A rule count beyond the table depth searches the whole table.
  assign n_eff = (32'(rule_count) > MAX_RULE_ENTRIES) ? RCNT_W'(MAX_RULE_ENTRIES)
                                                      : RCNT_W'(rule_count);

  // Rule writes go straight into the table; an index past its depth is dropped.
  assign r_we = accept && (req.op == OP_RULE) && (32'(req.rule_index) < MAX_RULE_ENTRIES);
  assign r_wdata = '{low_khz: req.rule_start_khz, end_khz: req.rule_end_khz,
                     band: req.rule_band, mode: req.rule_mode};

  bfd_rule_mem #(
    .DEPTH (MAX_RULE_ENTRIES),
    .AW    (RIDX_W)
  ) u_rule_mem (
    .clk   (clk),
    .we    (r_we),
    .waddr (RIDX_W'(req.rule_index)),
    .wdata (r_wdata),
    .raddr (r_addr),
    .rdata (r_rdata)
  );

  // Frame store: written at the byte position; the read data is registered from the address.
  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[pos[FIDX_W-1:0]] <= req.serial_byte;
    end
    f_rdata <= fmem[rd_addr];
  end

  // Sequencer. A frame end reads byte 4 for the command check, then the five frequency
  // pairs from the most significant down, scales to kHz and walks the rules in order.
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    out_valid_next = out_valid;
    rd_addr_next   = rd_addr;
    dig_cnt_next   = dig_cnt;
    acc_next       = acc;
    prod_next      = prod;
    n_reg_next     = n_reg;
    srch_idx_next  = srch_idx;
    r_addr_next    = r_addr;
    hit_band_next  = hit_band;
    hit_mode_next  = hit_mode;
    out_band_next  = out_band;
    out_mode_next  = out_mode;
    f_we           = 1'b0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept && (req.op == OP_BYTE)) begin
          if ((pos == '0) && (req.serial_byte != MARK_START)) begin
            // Noise between frames is ignored.
            pos_next = pos;
          end else if ((pos == POS_W'(1)) && (req.serial_byte != MARK_START)) begin
            pos_next = '0;
          end else if (pos >= POS_W'(FRAME_BYTES)) begin
            // Overflow drops the frame and the byte with it.
            pos_next = '0;
          end else begin
            f_we     = 1'b1;
            pos_next = pos + POS_W'(1);
            if (req.serial_byte == MARK_END) begin
              pos_next = '0;
              if (pos >= POS_W'(MIN_FRAME - 1)) begin
                rd_addr_next = FIDX_W'(CMD_POS);
                state_next   = S_HDR_RD;
              end
            end
          end
        end
      end
      S_HDR_RD: begin
        rd_addr_next = FIDX_W'(FREQ_MSB_POS);
        state_next   = S_HDR_CHK;
      end
      S_HDR_CHK: begin
        rd_addr_next = rd_addr - FIDX_W'(1);
        acc_next     = '0;
        dig_cnt_next = '0;
        if ((f_rdata == CMD_FREQ) || (f_rdata == CMD_READ)) begin
          state_next = S_DIGIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIGIT: begin
        acc_next     = acc_mul + 32'(digit);
        rd_addr_next = rd_addr - FIDX_W'(1);
        dig_cnt_next = dig_cnt + 3'd1;
        if (dig_cnt == 3'(DIGIT_PAIRS - 1)) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        prod_next  = 64'(acc) * 64'(KHZ_RECIP);
        state_next = S_QUOT;
      end
      S_QUOT: begin
        n_reg_next    = n_eff;
        srch_idx_next = '0;
        r_addr_next   = '0;
        if (n_eff == '0) begin
          hit_band_next = '0;
          hit_mode_next = '0;
          state_next    = S_EMIT;
        end else begin
          state_next = S_RULE_RD;
        end
      end
      S_RULE_RD: begin
        r_addr_next = r_addr + RIDX_W'(1);
        state_next  = S_SEARCH;
      end
      S_SEARCH: begin
        // The registered entry of the previous address is compared while the next one is fetched.
        if (rule_hit) begin
          hit_band_next = r_rdata.band;
          hit_mode_next = r_rdata.mode;
          state_next    = S_EMIT;
        end else if (srch_idx == n_reg - RCNT_W'(1)) begin
          hit_band_next = '0;
          hit_mode_next = '0;
          state_next    = S_EMIT;
        end else begin
          srch_idx_next = srch_idx + RCNT_W'(1);
          r_addr_next   = r_addr + RIDX_W'(1);
        end
      end
      S_EMIT: begin
        // Wait here only while the previous result has not been taken.
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_band_next  = hit_band;
          out_mode_next  = hit_mode;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      out_valid  <= 1'b0;
      rule_count <= '0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        rule_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr  <= rd_addr_next;
    dig_cnt  <= dig_cnt_next;
    acc      <= acc_next;
    prod     <= prod_next;
    n_reg    <= n_reg_next;
    srch_idx <= srch_idx_next;
    r_addr   <= r_addr_next;
    hit_band <= hit_band_next;
    hit_mode <= hit_mode_next;
    out_band <= out_band_next;
    out_mode <= out_mode_next;
  end

`ifndef SYNTHESIS
  // A new result appears only from the emit step.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result raised outside the emit step");

  // Neither memory is written while a frame end is being processed.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (!f_we && !r_we))
    else $error("memory written while the sequencer is busy");

  // The search never compares an entry past the enabled rule count.
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (srch_idx < n_reg))
    else $error("rule search ran past the enabled rules");

  // The byte position never goes past the store depth.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (pos <= POS_W'(FRAME_BYTES)))
    else $error("byte position beyond the frame store");
`endif

endmodule
